// ===== hw/rtl/gmpc_pkg.sv =====
// gmpc_pkg: shared constants, types and helpers for the glyph mask compositor
// no dependencies; imported by the gmpc datapath modules, the top level and the bench
`timescale 1ns / 1ps

package gmpc_pkg;

  localparam int TARGET_DIM = 4096;
  localparam int MASK_DIM   = 256;
  localparam int NUM_MAX    = 16;
  localparam int DEN_MAX    = 1024;

  localparam int GLYPH_W = 25;
  localparam int NUM_W   = 5;
  localparam int DEN_W   = 11;
  localparam int CLIP_W  = 13;
  localparam int PIX_W   = 12;

  // quotient bits produced by the cell chain; the top bit flags a quotient past range
  localparam int QUO_W   = 14;
  localparam int DIV_CELLS = QUO_W;
  localparam int PROD_W  = 30;
  localparam int MAG_W   = 29;
  localparam int DVS_W   = DEN_W + QUO_W - 1;
  localparam int POS_W   = 16;

  typedef enum logic [2:0] {
    REG_FOREGROUND = 3'd0,
    REG_SCALE_NUM  = 3'd1,
    REG_SCALE_DEN  = 3'd2,
    REG_CLIP_LEFT  = 3'd3,
    REG_CLIP_TOP   = 3'd4,
    REG_CLIP_RIGHT = 3'd5,
    REG_CLIP_BOT   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [9:0] bearing_x;
    logic signed [9:0] bearing_top;
    logic [7:0]        mask_x;
    logic [7:0]        mask_y;
    logic [7:0]        coverage;
    logic [7:0]        dest_red;
    logic [7:0]        dest_green;
    logic [7:0]        dest_blue;
    logic [7:0]        dest_alpha;
  } side_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t x;
    div_lane_t y;
    side_t     side;
  } div_item_t;

  typedef struct packed {
    logic [31:0]       fg_rgba;
    logic [CLIP_W-1:0] clip_left;
    logic [CLIP_W-1:0] clip_top;
    logic [CLIP_W-1:0] clip_right;
    logic [CLIP_W-1:0] clip_bottom;
  } blend_cfg_t;

  typedef struct packed {
    logic             write_pixel;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [7:0]       out_alpha;
  } result_t;

  // rounded sums stay below 65536 - 256, so the add-and-shift form is exact
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [15:0] t;
    t = s + 16'd1 + (s >> 8);
    return t[15:8];
  endfunction

endpackage

// ===== hw/rtl/gmpc_prep.sv =====
// gmpc_prep: scale multiply and sign/magnitude split ahead of the divider chain
// depends on gmpc_pkg
`timescale 1ns / 1ps

module gmpc_prep (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [gmpc_pkg::GLYPH_W-1:0] glyph_x,
  input  logic signed [gmpc_pkg::GLYPH_W-1:0] glyph_y,
  input  gmpc_pkg::side_t                   side_in,
  input  logic [gmpc_pkg::NUM_W-1:0]        scale_num,
  input  logic [gmpc_pkg::DEN_W-1:0]        scale_den,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gmpc_pkg::div_item_t               out_item
);
  import gmpc_pkg::*;

  logic                     va;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  side_t                    side_a;
  logic                     ready_a;
  logic                     ready_b;

  logic signed [GLYPH_W+NUM_W:0] px_full;
  logic signed [GLYPH_W+NUM_W:0] py_full;
  logic [PROD_W-1:0]             px_neg;
  logic [PROD_W-1:0]             py_neg;

  assign px_full = glyph_x * $signed({1'b0, scale_num});
  assign py_full = glyph_y * $signed({1'b0, scale_num});
  assign px_neg  = -px;
  assign py_neg  = -py;

  assign ready_b  = !out_valid || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
    if (ready_a) begin
      px     <= px_full[PROD_W-1:0];
      py     <= py_full[PROD_W-1:0];
      side_a <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_b) begin
      out_valid <= va;
    end
    if (ready_b) begin
      out_item.x.neg <= px[PROD_W-1];
      out_item.x.rem <= px[PROD_W-1] ? px_neg[MAG_W-1:0] : px[MAG_W-1:0];
      out_item.x.dvs <= {scale_den, {(QUO_W-1){1'b0}}};
      out_item.x.quo <= '0;
      out_item.y.neg <= py[PROD_W-1];
      out_item.y.rem <= py[PROD_W-1] ? py_neg[MAG_W-1:0] : py[MAG_W-1:0];
      out_item.y.dvs <= {scale_den, {(QUO_W-1){1'b0}}};
      out_item.y.quo <= '0;
      out_item.side  <= side_a;
    end
  end

endmodule

// ===== hw/rtl/gmpc_div_cell.sv =====
// gmpc_div_cell: one restoring division step for both axes, passes the item on
// depends on gmpc_pkg
`timescale 1ns / 1ps

module gmpc_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gmpc_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output gmpc_pkg::div_item_t out_item
);
  import gmpc_pkg::*;

  function automatic div_lane_t step(input div_lane_t l);
    div_lane_t r;
    logic [MAG_W-1:0] d;
    d = MAG_W'(l.dvs);
    r = l;
    if (l.rem >= d) begin
      r.rem = l.rem - d;
      r.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    r.dvs = l.dvs >> 1;
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_item.x    <= step(in_item.x);
      out_item.y    <= step(in_item.y);
      out_item.side <= in_item.side;
    end
  end

endmodule

// ===== hw/rtl/gmpc_blend.sv =====
// gmpc_blend: floor fix-up, target position, clip test and coverage blend
// depends on gmpc_pkg; holds the output register of the block
`timescale 1ns / 1ps

module gmpc_blend (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gmpc_pkg::div_item_t  in_item,
  input  gmpc_pkg::blend_cfg_t cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gmpc_pkg::result_t    out_res
);
  import gmpc_pkg::*;

  // first stage registers
  logic                    vf;
  logic                    ovf_x;
  logic                    ovf_y;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [15:0]             sum_r;
  logic [15:0]             sum_g;
  logic [15:0]             sum_b;
  logic [15:0]             sum_a;
  logic [7:0]              cov;
  logic [7:0]              mx;
  logic [7:0]              my;
  logic                    ready_f;

  logic [POS_W-1:0]        mag_x;
  logic [POS_W-1:0]        mag_y;
  logic signed [POS_W-1:0] sx;
  logic signed [POS_W-1:0] sy;
  logic [15:0]             inv_c;
  logic [15:0]             c16;
  logic                    hit;
  result_t                 res_next;

  // floor division: a negative dividend rounds away from zero when inexact
  always_comb begin
    mag_x = POS_W'(in_item.x.quo[QUO_W-2:0]) + POS_W'(in_item.x.rem != '0);
    mag_y = POS_W'(in_item.y.quo[QUO_W-2:0]) + POS_W'(in_item.y.rem != '0);
    sx = in_item.x.neg ? -$signed(mag_x) : $signed(POS_W'(in_item.x.quo[QUO_W-2:0]));
    sy = in_item.y.neg ? -$signed(mag_y) : $signed(POS_W'(in_item.y.quo[QUO_W-2:0]));
    c16   = 16'(in_item.side.coverage);
    inv_c = 16'd255 - c16;
  end

  assign in_ready = !vf || ready_f;
  assign ready_f  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (in_ready) begin
      vf <= in_valid;
    end
    if (in_ready) begin
      ovf_x <= in_item.x.quo[QUO_W-1];
      ovf_y <= in_item.y.quo[QUO_W-1];
      pos_x <= sx + POS_W'(in_item.side.bearing_x) + $signed(POS_W'(in_item.side.mask_x));
      pos_y <= sy - POS_W'(in_item.side.bearing_top) + $signed(POS_W'(in_item.side.mask_y));
      sum_r <= 16'(in_item.side.dest_red) * inv_c + 16'(cfg.fg_rgba[31:24]) * c16 + 16'd127;
      sum_g <= 16'(in_item.side.dest_green) * inv_c + 16'(cfg.fg_rgba[23:16]) * c16 + 16'd127;
      sum_b <= 16'(in_item.side.dest_blue) * inv_c + 16'(cfg.fg_rgba[15:8]) * c16 + 16'd127;
      sum_a <= 16'(in_item.side.dest_alpha) * inv_c + 16'd127;
      cov   <= in_item.side.coverage;
      mx    <= in_item.side.mask_x;
      my    <= in_item.side.mask_y;
    end
  end

  always_comb begin
    hit = (cfg.fg_rgba[7:0] != 8'd0) && (cov != 8'd0) &&
          ({1'b0, mx} < 9'(MASK_DIM)) && ({1'b0, my} < 9'(MASK_DIM)) &&
          !ovf_x && !ovf_y && !pos_x[POS_W-1] && !pos_y[POS_W-1] &&
          (pos_x < $signed(POS_W'(TARGET_DIM))) && (pos_y < $signed(POS_W'(TARGET_DIM))) &&
          (pos_x >= $signed(POS_W'(cfg.clip_left))) &&
          (pos_x <  $signed(POS_W'(cfg.clip_right))) &&
          (pos_y >= $signed(POS_W'(cfg.clip_top))) &&
          (pos_y <  $signed(POS_W'(cfg.clip_bottom)));
    res_next = '0;
    if (hit) begin
      res_next.write_pixel = 1'b1;
      res_next.pixel_x     = pos_x[PIX_W-1:0];
      res_next.pixel_y     = pos_y[PIX_W-1:0];
      res_next.out_red     = div255(sum_r);
      res_next.out_green   = div255(sum_g);
      res_next.out_blue    = div255(sum_b);
      res_next.out_alpha   = cov + div255(sum_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_f) begin
      out_valid <= vf;
    end
    if (ready_f) begin
      out_res <= res_next;
    end
  end

endmodule

// ===== hw/rtl/glyph_mask_pixel_compositor.sv =====
// glyph_mask_pixel_compositor: top level, config registers and the cell chain
// depends on gmpc_pkg, gmpc_prep, gmpc_div_cell, gmpc_blend
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata 128 bits, one glyph mask sample
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata 56 bits, tuser write flag
//   cfg       in         cfg_write                    cfg_index 3 bits, cfg_data 32 bits
//
// one item per clock while the output is not stalled; two prep stages, one
// division cell per quotient bit (14 cells) and two blend stages
// rst clears every stage valid bit and loads the register defaults
// each stage holds while the one after it is full and stalled; empty stages
// close up, so input is taken while a result waits at the output
`timescale 1ns / 1ps

module glyph_mask_pixel_compositor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // glyph_x, glyph_y, bearing_x, bearing_top, mask_x, mask_y,
  // coverage, dest_red, dest_green, dest_blue, dest_alpha, zero pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_x, pixel_y, out_red, out_green, out_blue, out_alpha
  output logic [55:0]  m_axis_tdata,
  // write_pixel
  output logic         m_axis_tuser,
  input  logic         cfg_write,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gmpc_pkg::*;

  logic [31:0]       foreground_rgba;
  logic [NUM_W-1:0]  scale_numerator;
  logic [DEN_W-1:0]  scale_denominator;
  logic [CLIP_W-1:0] clip_left;
  logic [CLIP_W-1:0] clip_top;
  logic [CLIP_W-1:0] clip_right;
  logic [CLIP_W-1:0] clip_bottom;

  logic [NUM_W-1:0]  num_c;
  logic [DEN_W-1:0]  den_c;
  side_t             side_in;
  blend_cfg_t        bcfg;
  result_t           res;

  div_item_t         chain_item  [DIV_CELLS+1];
  logic              chain_valid [DIV_CELLS+1];
  logic              chain_ready [DIV_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      foreground_rgba   <= 32'hFFFF_FFFF;
      scale_numerator   <= NUM_W'(1);
      scale_denominator <= DEN_W'(64);
      clip_left         <= '0;
      clip_top          <= '0;
      clip_right        <= CLIP_W'(TARGET_DIM);
      clip_bottom       <= CLIP_W'(TARGET_DIM);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOREGROUND: foreground_rgba   <= cfg_data;
        REG_SCALE_NUM:  scale_numerator   <= cfg_data[NUM_W-1:0];
        REG_SCALE_DEN:  scale_denominator <= cfg_data[DEN_W-1:0];
        REG_CLIP_LEFT:  clip_left         <= cfg_data[CLIP_W-1:0];
        REG_CLIP_TOP:   clip_top          <= cfg_data[CLIP_W-1:0];
        REG_CLIP_RIGHT: clip_right        <= cfg_data[CLIP_W-1:0];
        REG_CLIP_BOT:   clip_bottom       <= cfg_data[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // scale factors out of range count as the nearest legal value
  always_comb begin
    priority if (scale_numerator == '0) begin
      num_c = NUM_W'(1);
    end else if (scale_numerator > NUM_W'(NUM_MAX)) begin
      num_c = NUM_W'(NUM_MAX);
    end else begin
      num_c = scale_numerator;
    end
    priority if (scale_denominator == '0) begin
      den_c = DEN_W'(1);
    end else if (scale_denominator > DEN_W'(DEN_MAX)) begin
      den_c = DEN_W'(DEN_MAX);
    end else begin
      den_c = scale_denominator;
    end
  end

  assign side_in.bearing_x   = s_axis_tdata[59:50];
  assign side_in.bearing_top = s_axis_tdata[69:60];
  assign side_in.mask_x      = s_axis_tdata[77:70];
  assign side_in.mask_y      = s_axis_tdata[85:78];
  assign side_in.coverage    = s_axis_tdata[93:86];
  assign side_in.dest_red    = s_axis_tdata[101:94];
  assign side_in.dest_green  = s_axis_tdata[109:102];
  assign side_in.dest_blue   = s_axis_tdata[117:110];
  assign side_in.dest_alpha  = s_axis_tdata[125:118];

  gmpc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .glyph_x   (s_axis_tdata[24:0]),
    .glyph_y   (s_axis_tdata[49:25]),
    .side_in   (side_in),
    .scale_num (num_c),
    .scale_den (den_c),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
    gmpc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  assign bcfg.fg_rgba     = foreground_rgba;
  assign bcfg.clip_left   = clip_left;
  assign bcfg.clip_top    = clip_top;
  assign bcfg.clip_right  = clip_right;
  assign bcfg.clip_bottom = clip_bottom;

  gmpc_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[DIV_CELLS]),
    .in_ready  (chain_ready[DIV_CELLS]),
    .in_item   (chain_item[DIV_CELLS]),
    .cfg       (bcfg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tuser = res.write_pixel;
  assign m_axis_tdata = {res.out_alpha, res.out_blue, res.out_green, res.out_red,
                         res.pixel_y, res.pixel_x};

endmodule

// ===== hw/rtl/gmpc_checker.sv =====
// gmpc_checker: port-level checks on the compositor, bound to the top level
// depends on glyph_mask_pixel_compositor
`timescale 1ns / 1ps

module gmpc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [55:0]  m_axis_tdata,
  input logic         m_axis_tuser
);

  // a skipped pixel carries all-zero data
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 56'd0))
    else $error("skipped pixel with nonzero data");

  // the pipeline takes input whenever the output side can move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with a free output");

  // nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind glyph_mask_pixel_compositor gmpc_checker u_gmpc_checker (.*);

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for glyph_mask_pixel_compositor, sample stream in, pixel stream out
// depends on gmpc_pkg and the compositor rtl; predicts each pixel in-bench and checks in order
// random sender bursts, receiver stall patterns, a long output hold-off and config sweeps
`timescale 1ns / 1ps

module tb;
  import gmpc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;

  // declared msb first so glyph_x lands in the low bits of tdata
  typedef struct packed {
    logic [7:0]  dest_alpha;
    logic [7:0]  dest_blue;
    logic [7:0]  dest_green;
    logic [7:0]  dest_red;
    logic [7:0]  coverage;
    logic [7:0]  mask_y;
    logic [7:0]  mask_x;
    logic [9:0]  bearing_top;
    logic [9:0]  bearing_x;
    logic [24:0] glyph_y;
    logic [24:0] glyph_x;
  } sample_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_write = 1'b0;
  logic [2:0]   cfg_index = REG_FOREGROUND;
  logic [31:0]  cfg_data = '0;

  // register copies, kept at the width the block stores
  logic [31:0] fg_rgba   = 32'hFFFF_FFFF;
  int          scale_num = 1;
  int          scale_den = 64;
  int          clip_l    = 0;
  int          clip_t    = 0;
  int          clip_r    = 4096;
  int          clip_b    = 4096;

  result_t expected_pixels[$];
  int      mismatch_count = 0;
  int      stall_cycles = 0;
  int      burst_left = 0;
  bit      gaps_on = 1'b1;
  bit      hold_req = 1'b0;
  int      hold_cycles = 0;

  glyph_mask_pixel_compositor dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint eff_num();
    if (scale_num < 1) return 1;
    if (scale_num > NUM_MAX) return NUM_MAX;
    return scale_num;
  endfunction

  function automatic longint eff_den();
    if (scale_den < 1) return 1;
    if (scale_den > DEN_MAX) return DEN_MAX;
    return scale_den;
  endfunction

  // floor of q * num / den
  function automatic longint scaled_pos(input longint q, input longint num, input longint den);
    longint v;
    v = q * num;
    if (v >= 0) return v / den;
    return -((-v + den - 1) / den);
  endfunction

  function automatic int unsigned blend_channel(input int unsigned d, input int unsigned f,
                                                input int unsigned c);
    return (d * (255 - c) + f * c + 127) / 255;
  endfunction

  function automatic result_t predict_pixel(input sample_t s);
    result_t     r;
    longint      px, py, q;
    int unsigned cov, da;
    bit          hit;
    r = '0;
    q = $signed(s.glyph_x);
    px = scaled_pos(q, eff_num(), eff_den());
    q = $signed(s.bearing_x);
    px = px + q + longint'(s.mask_x);
    q = $signed(s.glyph_y);
    py = scaled_pos(q, eff_num(), eff_den());
    q = $signed(s.bearing_top);
    py = py - q + longint'(s.mask_y);
    cov = 32'(s.coverage);
    da = 32'(s.dest_alpha);
    hit = fg_rgba[7:0] != 8'd0 && cov != 0 &&
          px >= 0 && py >= 0 && px < TARGET_DIM && py < TARGET_DIM &&
          px >= clip_l && px < clip_r && py >= clip_t && py < clip_b;
    if (hit) begin
      r.write_pixel = 1'b1;
      r.pixel_x = px[PIX_W-1:0];
      r.pixel_y = py[PIX_W-1:0];
      r.out_red = 8'(blend_channel(32'(s.dest_red), 32'(fg_rgba[31:24]), cov));
      r.out_green = 8'(blend_channel(32'(s.dest_green), 32'(fg_rgba[23:16]), cov));
      r.out_blue = 8'(blend_channel(32'(s.dest_blue), 32'(fg_rgba[15:8]), cov));
      r.out_alpha = 8'(cov + (da * (255 - cov) + 127) / 255);
    end
    return r;
  endfunction

  function automatic sample_t make_sample(input longint gx, input longint gy,
                                          input longint bx, input longint bt,
                                          input int mx, input int my, input int cov,
                                          input logic [31:0] dest);
    sample_t s;
    s.glyph_x = gx[24:0];
    s.glyph_y = gy[24:0];
    s.bearing_x = bx[9:0];
    s.bearing_top = bt[9:0];
    s.mask_x = mx[7:0];
    s.mask_y = my[7:0];
    s.coverage = cov[7:0];
    {s.dest_red, s.dest_green, s.dest_blue, s.dest_alpha} = dest;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.glyph_x = 25'($urandom);
    s.glyph_y = 25'($urandom);
    s.bearing_x = 10'($urandom);
    s.bearing_top = 10'($urandom);
    s.mask_x = 8'($urandom);
    s.mask_y = 8'($urandom);
    s.coverage = 8'($urandom);
    {s.dest_red, s.dest_green, s.dest_blue, s.dest_alpha} = $urandom;
    return s;
  endfunction

  // glyph position chosen so the pixel lands on or near the clip window
  function automatic sample_t aimed_sample();
    sample_t s;
    longint  num, den, lo, hi, tx, ty, g, b;
    s = random_sample();
    num = eff_num();
    den = eff_den();
    if ($urandom_range(0, 3) != 0) begin
      b = $urandom_range(0, 512);
      s.bearing_x = 10'(b - 256);
      b = $urandom_range(0, 512);
      s.bearing_top = 10'(b - 256);
    end
    case ($urandom_range(0, 7))
      0: s.coverage = 8'd0;
      1: s.coverage = 8'd255;
      default: ;
    endcase
    lo = (clip_l < clip_r) ? clip_l : clip_r;
    hi = (clip_l < clip_r) ? clip_r : clip_l;
    if (lo > TARGET_DIM) lo = TARGET_DIM;
    if (hi > TARGET_DIM) hi = TARGET_DIM;
    tx = lo - 4 + $urandom_range(0, hi - lo + 8);
    lo = (clip_t < clip_b) ? clip_t : clip_b;
    hi = (clip_t < clip_b) ? clip_b : clip_t;
    if (lo > TARGET_DIM) lo = TARGET_DIM;
    if (hi > TARGET_DIM) hi = TARGET_DIM;
    ty = lo - 4 + $urandom_range(0, hi - lo + 8);
    b = $signed(s.bearing_x);
    tx = tx - b - longint'(s.mask_x);
    b = $signed(s.bearing_top);
    ty = ty + b - longint'(s.mask_y);
    g = $urandom_range(0, 2);
    g = g - 1 + tx * den / num;
    if (g > 16777215) g = 16777215;
    if (g < -16777216) g = -16777216;
    s.glyph_x = g[24:0];
    g = $urandom_range(0, 2);
    g = g - 1 + ty * den / num;
    if (g > 16777215) g = 16777215;
    if (g < -16777216) g = -16777216;
    s.glyph_y = g[24:0];
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tdata <= {2'b00, s};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_pixels.push_back(predict_pixel(s));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_FOREGROUND: fg_rgba = val;
      REG_SCALE_NUM:  scale_num = 32'(val[NUM_W-1:0]);
      REG_SCALE_DEN:  scale_den = 32'(val[DEN_W-1:0]);
      REG_CLIP_LEFT:  clip_l = 32'(val[CLIP_W-1:0]);
      REG_CLIP_TOP:   clip_t = 32'(val[CLIP_W-1:0]);
      REG_CLIP_RIGHT: clip_r = 32'(val[CLIP_W-1:0]);
      REG_CLIP_BOT:   clip_b = 32'(val[CLIP_W-1:0]);
      default: ;
    endcase
  endtask

  // settle the pipe, load all registers, then stream mostly aimed samples
  task automatic run_config_phase(input logic [31:0] fg, input int num, input int den,
                                  input int l, input int t, input int r, input int b,
                                  input int count);
    drain();
    write_reg(REG_FOREGROUND, fg);
    write_reg(REG_SCALE_NUM, num);
    write_reg(REG_SCALE_DEN, den);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOT, b);
    cfg_write <= 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) send_sample(random_sample());
      else send_sample(aimed_sample());
    end
  endtask

  // reset config: num 1, den 64, clip is the whole target, white foreground
  task automatic test_directed_extremes();
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 255, 32'h0000_0000));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 32'h1234_5678));
    send_sample(make_sample(6400, 12800, 0, 0, 0, 0, 1, 32'hFFFF_FFFF));
    send_sample(make_sample(-1, -1, 0, 0, 5, 5, 128, 32'h0A14_1E28));
    send_sample(make_sample(-65, 0, 0, 0, 3, 0, 200, 32'h55AA_55AA));
    send_sample(make_sample(16777215, 0, 0, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(-16777216, 0, 0, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(0, 16777215, 0, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(0, -16777216, 0, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(38400, 38400, -512, 511, 0, 0, 77, 32'h8040_2010));
    send_sample(make_sample(0, 0, 511, -512, 0, 0, 254, 32'hFEDC_BA98));
    send_sample(make_sample(64 * 4095, 64 * 4095, 0, 0, 0, 0, 127, 32'hAA55_AA55));
    send_sample(make_sample(64 * 4096, 0, 0, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(0, 64 * 4096, 0, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(64 * 3840, 64 * 3840, 0, 0, 255, 255, 255, 32'hFFFF_FFFF));
    send_sample(make_sample(0, 0, -1, 0, 0, 0, 255, 32'h0));
    send_sample(make_sample(0, 0, 0, 1, 0, 0, 255, 32'h0));
    send_sample(make_sample(64 * 1000 + 63, 64 * 50 + 1, 0, 0, 0, 0, 129, 32'h00FF_00FF));
    send_sample(make_sample(-64 * 3, -64 * 3, 10, -10, 0, 0, 64, 32'hFF00_FF00));
    send_sample(make_sample(1, 1, 256, -256, 128, 128, 192, 32'h7F80_7F80));
    send_sample(make_sample(-64 * 256, 64 * 10, 256, 256, 0, 255, 1, 32'h0102_0304));
    send_sample(make_sample(64 * 20, 64 * 20, -256, 256, 255, 0, 255, 32'hFFFF_FFFF));
  endtask

  task automatic test_config_cases();
    // transparent foreground
    run_config_phase(32'h1234_5600, 1, 64, 0, 0, 4096, 4096, 12);
    // empty clip, columns then rows
    run_config_phase(32'hFFFF_FFFF, 1, 64, 100, 0, 100, 4096, 8);
    run_config_phase(32'hFFFF_FFFF, 1, 64, 0, 300, 4096, 200, 8);
    // clip wider than the target, bound by the target edge
    run_config_phase(32'hA5C3_0F01, 1, 64, 0, 0, 8191, 8191, 12);
    run_config_phase(32'h0000_00FF, 1, 64, 8191, 8191, 8191, 8191, 6);
    // zero scale registers count as one
    run_config_phase(32'h0000_00FF, 0, 0, 0, 0, 4096, 4096, 10);
    // scale registers above range clamp, then scale values at the range limits
    run_config_phase(32'h5A3C_96FF, 31, 2047, 1000, 2000, 1200, 2100, 10);
    run_config_phase(32'hFFFF_FFFF, 16, 1, 10, 20, 42, 52, 10);
    run_config_phase(32'h8080_8080, 1, 1024, 4095, 4095, 4096, 4096, 8);
    run_config_phase(32'h0000_0001, 16, 1024, 0, 0, 1, 1, 8);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_cycles = 300;
    hold_req = 1'b1;
    repeat (120) send_sample(aimed_sample());
    gaps_on = 1'b1;
    burst_left = 0;
    drain();
  endtask

  task automatic test_pause_until_drained();
    repeat (40) send_sample(aimed_sample());
    drain();
    repeat (40) send_sample(aimed_sample());
    drain();
  endtask

  task automatic test_random_configs();
    logic [31:0] fg;
    int          num, den, l, t, r, b;
    repeat (12) begin
      fg = $urandom;
      if ($urandom_range(0, 7) == 0) fg[7:0] = 8'd0;
      num = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      case ($urandom_range(0, 4))
        0: den = $urandom_range(0, 2047);
        1: den = $urandom_range(1, 8);
        2: den = 64;
        default: den = $urandom_range(1, 1024);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        l = $urandom_range(0, 8191);
        t = $urandom_range(0, 8191);
        r = $urandom_range(0, 8191);
        b = $urandom_range(0, 8191);
      end else begin
        l = $urandom_range(0, 4095);
        t = $urandom_range(0, 4095);
        r = $urandom_range(l + 1, 4096);
        b = $urandom_range(t + 1, 4096);
      end
      run_config_phase(fg, num, den, l, t, r, b, 110);
    end
  endtask

  initial begin : receiver
    rx_mode_t mode;
    int       left, phase;
    mode = RX_ALWAYS;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(32, 200);
        end
        left--;
        phase++;
        case (mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
          default:   m_axis_tready <= (phase % 5 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.write_pixel = m_axis_tuser;
      {got.out_alpha, got.out_blue, got.out_green, got.out_red, got.pixel_y, got.pixel_x} =
        m_axis_tdata;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected item: w=%0d x=%0d y=%0d rgba=%h%h%h%h", got.write_pixel,
                   got.pixel_x, got.pixel_y, got.out_red, got.out_green, got.out_blue,
                   got.out_alpha);
      end else begin
        want = expected_pixels.pop_front();
        if (got.write_pixel !== want.write_pixel || got.pixel_x !== want.pixel_x ||
            got.pixel_y !== want.pixel_y || got.out_red !== want.out_red ||
            got.out_green !== want.out_green || got.out_blue !== want.out_blue ||
            got.out_alpha !== want.out_alpha) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("pixel mismatch: expected w=%0d x=%0d y=%0d rgba=%h%h%h%h,",
                     want.write_pixel, want.pixel_x, want.pixel_y, want.out_red,
                     want.out_green, want.out_blue, want.out_alpha,
                     " got w=%0d x=%0d y=%0d rgba=%h%h%h%h", got.write_pixel,
                     got.pixel_x, got.pixel_y, got.out_red, got.out_green, got.out_blue,
                     got.out_alpha);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_config_cases();
    test_output_hold();
    test_pause_until_drained();
    test_random_configs();
    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
